// File: rtl/core/ppp_pkg.sv
// Shared types and constants for the pinhole point projection block.
package ppp_pkg;

	localparam int COORD_FRAC_BITS_DEF = 16;
	localparam int CAM_W = 39;
	localparam int MAG_W = 38;
	localparam int QUO_W = 32;
	localparam int DIV_LAT = QUO_W + 1;
	localparam int FIFO_DEPTH = 8;
	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
	localparam int FRONT_STAGES = 5;
	localparam int FLY_W = $clog2(FRONT_STAGES + 1);

	localparam logic signed [CAM_W-1:0] CAM_LIMIT = 39'sh3F_FFFF_FFFF;

	localparam logic [23:0] FOCAL_X_RST = 24'd128000;
	localparam logic [23:0] FOCAL_Y_RST = 24'd128000;
	localparam logic [23:0] CENTER_X_RST = 24'd81920;
	localparam logic [23:0] CENTER_Y_RST = 24'd61440;
	localparam logic [30:0] MIN_DEPTH_RST = 31'd3277;

	typedef enum logic [2:0] {
		REG_FOCAL_X = 3'd0,
		REG_FOCAL_Y = 3'd1,
		REG_CENTER_X = 3'd2,
		REG_CENTER_Y = 3'd3,
		REG_MIN_DEPTH = 3'd4
	} ppp_reg_t;

	typedef struct packed {
		logic [23:0] focal_x;
		logic [23:0] focal_y;
		logic [23:0] center_x;
		logic [23:0] center_y;
		logic [30:0] min_depth;
	} ppp_cfg_t;

	typedef struct packed {
		logic vis;
		logic signed [CAM_W-1:0] cx;
		logic signed [CAM_W-1:0] cy;
		logic signed [CAM_W-1:0] cz;
	} ppp_item_t;

	typedef struct packed {
		logic vld;
		logic vis;
		logic neg_u;
		logic neg_v;
	} ppp_ctl_t;

endpackage

// File: rtl/core/ppp_front.sv
// Front end: point transform into the camera frame, depth cull and image bounds test.
module ppp_front import ppp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic accept,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] point_z,
	input  logic signed [31:0] cam_pos_x,
	input  logic signed [31:0] cam_pos_y,
	input  logic signed [31:0] cam_pos_z,
	input  logic signed [15:0] quat_w,
	input  logic signed [15:0] quat_x,
	input  logic signed [15:0] quat_y,
	input  logic signed [15:0] quat_z,
	input  ppp_cfg_t cfg,
	output logic push,
	output ppp_item_t item,
	output logic [FLY_W-1:0] inflight
);

	function automatic logic signed [20:0] rnd14(input logic signed [34:0] v);
		logic signed [34:0] t;
		t = (v + 35'sd8192) >>> 14;
		return t[20:0];
	endfunction

	function automatic logic signed [CAM_W-1:0] cam_round(input logic signed [55:0] v);
		logic signed [55:0] t;
		t = (v + 56'sd8192) >>> 14;
		if (t > 56'(CAM_LIMIT))
			return CAM_LIMIT;
		else if (t < -56'(CAM_LIMIT))
			return -CAM_LIMIT;
		else
			return t[CAM_W-1:0];
	endfunction

	localparam logic signed [34:0] ONE_Q28 = 35'sd268435456;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	// stage 1: differences and quaternion products
	logic signed [32:0] dx_s1, dy_s1, dz_s1;
	logic signed [31:0] xx_s1, yy_s1, zz_s1, xy_s1, zw_s1, xz_s1, yw_s1, yz_s1, xw_s1;

	// stage 2: rotation entries
	logic signed [32:0] dx_s2, dy_s2, dz_s2;
	logic signed [20:0] r00_s2, r01_s2, r02_s2, r10_s2, r11_s2, r12_s2;
	logic signed [20:0] r20_s2, r21_s2, r22_s2;

	// stage 3: matrix products
	logic signed [53:0] mx0_s3, mx1_s3, mx2_s3, my0_s3, my1_s3, my2_s3;
	logic signed [53:0] mz0_s3, mz1_s3, mz2_s3;

	// stage 4: camera frame point
	logic signed [CAM_W-1:0] cx_s4, cy_s4, cz_s4;

	// stage 5: bounds products
	logic signed [CAM_W-1:0] cx_s5, cy_s5, cz_s5;
	logic signed [63:0] px_s5, bx_s5, py_s5, by_s5;
	logic depth_ok_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1 <= 33'(point_x) - 33'(cam_pos_x);
		dy_s1 <= 33'(point_y) - 33'(cam_pos_y);
		dz_s1 <= 33'(point_z) - 33'(cam_pos_z);
		xx_s1 <= quat_x * quat_x;
		yy_s1 <= quat_y * quat_y;
		zz_s1 <= quat_z * quat_z;
		xy_s1 <= quat_x * quat_y;
		zw_s1 <= quat_z * quat_w;
		xz_s1 <= quat_x * quat_z;
		yw_s1 <= quat_y * quat_w;
		yz_s1 <= quat_y * quat_z;
		xw_s1 <= quat_x * quat_w;
	end

	always_ff @(posedge clk) begin
		dx_s2 <= dx_s1;
		dy_s2 <= dy_s1;
		dz_s2 <= dz_s1;
		r00_s2 <= rnd14(ONE_Q28 - ((35'(yy_s1) + 35'(zz_s1)) <<< 1));
		r01_s2 <= rnd14((35'(xy_s1) - 35'(zw_s1)) <<< 1);
		r02_s2 <= rnd14((35'(xz_s1) + 35'(yw_s1)) <<< 1);
		r10_s2 <= rnd14((35'(xy_s1) + 35'(zw_s1)) <<< 1);
		r11_s2 <= rnd14(ONE_Q28 - ((35'(xx_s1) + 35'(zz_s1)) <<< 1));
		r12_s2 <= rnd14((35'(yz_s1) - 35'(xw_s1)) <<< 1);
		r20_s2 <= rnd14((35'(xz_s1) - 35'(yw_s1)) <<< 1);
		r21_s2 <= rnd14((35'(yz_s1) + 35'(xw_s1)) <<< 1);
		r22_s2 <= rnd14(ONE_Q28 - ((35'(xx_s1) + 35'(yy_s1)) <<< 1));
	end

	// transpose: camera point = R^T * d
	always_ff @(posedge clk) begin
		mx0_s3 <= r00_s2 * dx_s2;
		mx1_s3 <= r10_s2 * dy_s2;
		mx2_s3 <= r20_s2 * dz_s2;
		my0_s3 <= r01_s2 * dx_s2;
		my1_s3 <= r11_s2 * dy_s2;
		my2_s3 <= r21_s2 * dz_s2;
		mz0_s3 <= r02_s2 * dx_s2;
		mz1_s3 <= r12_s2 * dy_s2;
		mz2_s3 <= r22_s2 * dz_s2;
	end

	always_ff @(posedge clk) begin
		cx_s4 <= cam_round(56'(mx0_s3) + 56'(mx1_s3) + 56'(mx2_s3));
		cy_s4 <= cam_round(56'(my0_s3) + 56'(my1_s3) + 56'(my2_s3));
		cz_s4 <= cam_round(56'(mz0_s3) + 56'(mz1_s3) + 56'(mz2_s3));
	end

	always_ff @(posedge clk) begin
		cx_s5 <= cx_s4;
		cy_s5 <= cy_s4;
		cz_s5 <= cz_s4;
		px_s5 <= $signed({1'b0, cfg.focal_x}) * cx_s4;
		bx_s5 <= $signed({1'b0, cfg.center_x}) * cz_s4;
		py_s5 <= $signed({1'b0, cfg.focal_y}) * cy_s4;
		by_s5 <= $signed({1'b0, cfg.center_y}) * cz_s4;
		depth_ok_s5 <= 40'(cz_s4) > $signed({9'b0, cfg.min_depth});
	end

	always_comb begin
		push = v_s5;
		item.cx = cx_s5;
		item.cy = cy_s5;
		item.cz = cz_s5;
		item.vis = depth_ok_s5 &&
			(px_s5 >= -bx_s5) && (px_s5 < bx_s5) &&
			(py_s5 >= -by_s5) && (py_s5 < by_s5);
	end

	assign inflight = FLY_W'($countones({v_s1, v_s2, v_s3, v_s4, v_s5}));

endmodule

// File: rtl/core/ppp_fifo.sv
// Short queue between front and back; drains one entry each cycle it holds one.
module ppp_fifo import ppp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  ppp_item_t din,
	output logic pop,
	output ppp_item_t dout,
	output logic [CNT_W-1:0] count
);

	ppp_item_t mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign pop = cnt_q != '0;
	assign dout = mem_q[rd_q];
	assign count = cnt_q;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

endmodule

// File: rtl/core/ppp_div.sv
// Pipelined restoring divider lane, one quotient bit per stage, with overflow flag.
module ppp_div import ppp_pkg::*; #(
	parameter int NW = MAG_W + COORD_FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic [NW-1:0] num,
	input  logic [MAG_W-1:0] den,
	output logic [QUO_W-1:0] quo,
	output logic ovf
);

	localparam int RW = MAG_W + QUO_W + 1;

	logic [RW-1:0] rem_s [0:QUO_W];
	logic [MAG_W-1:0] den_s [0:QUO_W];
	logic [QUO_W-1:0] quo_s [0:QUO_W];
	logic ovf_s [0:QUO_W];

	always_ff @(posedge clk) begin
		rem_s[0] <= RW'(num);
		den_s[0] <= den;
		quo_s[0] <= '0;
		ovf_s[0] <= RW'(num >> QUO_W) >= RW'(den);
	end

	for (genvar k = 1; k <= QUO_W; k++) begin : g_step
		logic [RW-1:0] sh;
		logic ge;
		assign sh = RW'(den_s[k-1]) << (QUO_W - k);
		assign ge = rem_s[k-1] >= sh;
		always_ff @(posedge clk) begin
			rem_s[k] <= ge ? rem_s[k-1] - sh : rem_s[k-1];
			den_s[k] <= den_s[k-1];
			ovf_s[k] <= ovf_s[k-1];
			quo_s[k] <= quo_s[k-1] | (QUO_W'(ge) << (QUO_W - k));
		end
	end

	assign quo = quo_s[QUO_W];
	assign ovf = ovf_s[QUO_W];

endmodule

// File: rtl/core/ppp_back.sv
// Back end: signed x/z and y/z with saturation, result register and strobe.
module ppp_back import ppp_pkg::*; #(
	parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  ppp_item_t item,
	output logic done,
	output logic visible,
	output logic signed [31:0] norm_u,
	output logic signed [31:0] norm_v
);

	localparam int NW = MAG_W + COORD_FRAC_BITS;

	function automatic logic [MAG_W-1:0] mag(input logic signed [CAM_W-1:0] v);
		logic signed [CAM_W-1:0] t;
		t = v[CAM_W-1] ? -v : v;
		return t[MAG_W-1:0];
	endfunction

	function automatic logic [31:0] sat(input logic [QUO_W-1:0] q, input logic o,
		input logic neg);
		if (neg)
			return (o || q[QUO_W-1]) ? 32'h8000_0000 : 32'(-q);
		else
			return (o || q[QUO_W-1]) ? 32'h7FFF_FFFF : q;
	endfunction

	ppp_ctl_t ctl_s0;
	ppp_ctl_t ctl_q [0:DIV_LAT-1];
	logic [NW-1:0] nu_s0, nv_s0;
	logic [MAG_W-1:0] den_s0;
	logic [QUO_W-1:0] qu, qv;
	logic ou, ov;
	logic done_q, visible_q;
	logic [31:0] norm_u_q, norm_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s0 <= '0;
			for (int i = 0; i < DIV_LAT; i++)
				ctl_q[i] <= '0;
			done_q <= 1'b0;
			visible_q <= 1'b0;
		end else begin
			ctl_s0.vld <= in_valid;
			ctl_s0.vis <= in_valid & item.vis;
			ctl_s0.neg_u <= item.cx[CAM_W-1];
			ctl_s0.neg_v <= item.cy[CAM_W-1];
			ctl_q[0] <= ctl_s0;
			for (int i = 1; i < DIV_LAT; i++)
				ctl_q[i] <= ctl_q[i-1];
			done_q <= ctl_q[DIV_LAT-1].vld;
			visible_q <= ctl_q[DIV_LAT-1].vld & ctl_q[DIV_LAT-1].vis;
		end
	end

	always_ff @(posedge clk) begin
		nu_s0 <= NW'(mag(item.cx)) << COORD_FRAC_BITS;
		nv_s0 <= NW'(mag(item.cy)) << COORD_FRAC_BITS;
		den_s0 <= item.cz[MAG_W-1:0];
	end

	ppp_div #(.NW(NW)) u_div_u (
		.clk(clk),
		.num(nu_s0),
		.den(den_s0),
		.quo(qu),
		.ovf(ou)
	);

	ppp_div #(.NW(NW)) u_div_v (
		.clk(clk),
		.num(nv_s0),
		.den(den_s0),
		.quo(qv),
		.ovf(ov)
	);

	always_ff @(posedge clk) begin
		if (ctl_q[DIV_LAT-1].vis) begin
			norm_u_q <= sat(qu, ou, ctl_q[DIV_LAT-1].neg_u);
			norm_v_q <= sat(qv, ov, ctl_q[DIV_LAT-1].neg_v);
		end else begin
			norm_u_q <= '0;
			norm_v_q <= '0;
		end
	end

	assign done = done_q;
	assign visible = visible_q;
	assign norm_u = norm_u_q;
	assign norm_v = norm_v_q;

endmodule

// File: rtl/core/pinhole_point_projection.sv
// Top level of the pinhole point projection block with frustum cull.
// A point passes the front stages, the queue, the back input register and the divider stages to the done register.
// Throughput: one point per cycle while busy is low; front multipliers and both dividers are pipelined.
// busy rises only if the front-to-back queue could overflow; the result side has no stall.
// Reset (arst_n low, asynchronous) empties the pipeline and queue and reloads the registers.
module pinhole_point_projection import ppp_pkg::*; #(
	parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] point_z,
	input  logic signed [31:0] cam_pos_x,
	input  logic signed [31:0] cam_pos_y,
	input  logic signed [31:0] cam_pos_z,
	input  logic signed [15:0] quat_w,
	input  logic signed [15:0] quat_x,
	input  logic signed [15:0] quat_y,
	input  logic signed [15:0] quat_z,
	output logic done,
	output logic visible,
	output logic signed [31:0] norm_u,
	output logic signed [31:0] norm_v,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [31:0] cfg_data
);

	ppp_cfg_t cfg_q;
	logic accept, push, pop;
	ppp_item_t item_in, item_out;
	logic [CNT_W-1:0] count;
	logic [FLY_W-1:0] inflight;

	assign cfg_ready = 1'b1;
	assign busy = ({1'b0, count} + (CNT_W+1)'(inflight)) >= (CNT_W+1)'(FIFO_DEPTH);
	assign accept = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.focal_x <= FOCAL_X_RST;
			cfg_q.focal_y <= FOCAL_Y_RST;
			cfg_q.center_x <= CENTER_X_RST;
			cfg_q.center_y <= CENTER_Y_RST;
			cfg_q.min_depth <= MIN_DEPTH_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (ppp_reg_t'(cfg_index))
				REG_FOCAL_X: cfg_q.focal_x <= cfg_data[23:0];
				REG_FOCAL_Y: cfg_q.focal_y <= cfg_data[23:0];
				REG_CENTER_X: cfg_q.center_x <= cfg_data[23:0];
				REG_CENTER_Y: cfg_q.center_y <= cfg_data[23:0];
				REG_MIN_DEPTH: cfg_q.min_depth <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	ppp_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.point_x(point_x),
		.point_y(point_y),
		.point_z(point_z),
		.cam_pos_x(cam_pos_x),
		.cam_pos_y(cam_pos_y),
		.cam_pos_z(cam_pos_z),
		.quat_w(quat_w),
		.quat_x(quat_x),
		.quat_y(quat_y),
		.quat_z(quat_z),
		.cfg(cfg_q),
		.push(push),
		.item(item_in),
		.inflight(inflight)
	);

	ppp_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.din(item_in),
		.pop(pop),
		.dout(item_out),
		.count(count)
	);

	ppp_back #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(pop),
		.item(item_out),
		.done(done),
		.visible(visible),
		.norm_u(norm_u),
		.norm_v(norm_v)
	);

endmodule

// File: rtl/core/ppp_check.sv
// Port-level checker for the pinhole point projection block, bound to the top level.
module ppp_check (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic visible,
	input logic signed [31:0] norm_u,
	input logic signed [31:0] norm_v,
	input logic cfg_valid,
	input logic cfg_ready
);

	a_culled_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !visible |-> norm_u == 32'sd0 && norm_v == 32'sd0)
		else $error("culled result carries non-zero coordinates");

	a_vis_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> !visible)
		else $error("visible high without a result transfer");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration transfer refused");

	a_reset_quiet: assert property (@(posedge clk) !arst_n |=> !done)
		else $error("result strobe straight after reset");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##41 done)
		else $error("no result transfer 41 cycles after an input transfer");

endmodule

bind pinhole_point_projection ppp_check u_ppp_check (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.done(done),
	.visible(visible),
	.norm_u(norm_u),
	.norm_v(norm_v),
	.cfg_valid(cfg_valid),
	.cfg_ready(cfg_ready)
);

// File: bench/tb_pinhole_point_projection.sv
// Self-checking testbench for the pinhole point projection block.
module tb_pinhole_point_projection;
	import ppp_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 60;
	localparam logic [2:0] REG_UNUSED_HI = 3'd7;
	localparam logic [2:0] REG_UNUSED_LO = 3'd5;

	typedef struct {
		logic signed [31:0] px, py, pz, cx, cy, cz;
		logic signed [15:0] qw, qx, qy, qz;
	} point_t;

	typedef struct {
		logic vis;
		logic signed [31:0] u, v;
	} proj_t;

	typedef enum {ROW_POINT, ROW_REG} row_kind_t;

	typedef struct {
		row_kind_t kind;
		point_t pt;
		bit typed;
		proj_t res;
		logic [2:0] idx;
		logic [31:0] data;
	} row_t;

	logic clk, arst_n, start, busy, done, visible, cfg_valid, cfg_ready;
	logic signed [31:0] point_x, point_y, point_z, cam_pos_x, cam_pos_y, cam_pos_z;
	logic signed [15:0] quat_w, quat_x, quat_y, quat_z;
	logic signed [31:0] norm_u, norm_v;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;

	longint fx_q, fy_q, cx_q, cy_q, mind_q;
	proj_t pending_proj[$];
	bit typed_now;
	proj_t typed_res;
	int n_taken, n_regs, n_fail, cycles, sender_idle;
	row_t rows[$];

	pinhole_point_projection DUT (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	function automatic longint rnd14(longint v);
		return (v + 8192) >>> 14;
	endfunction

	function automatic longint clamp_cam(longint v);
		if (v > 64'sd274877906943) return 64'sd274877906943;
		if (v < -64'sd274877906943) return -64'sd274877906943;
		return v;
	endfunction

	function automatic logic signed [31:0] sat32(longint v);
		if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic bit in_image(longint f, longint a, longint c, longint z);
		longint lhs, bound;
		lhs = f * a;
		bound = c * z;
		return lhs >= -bound && lhs < bound;
	endfunction

	function automatic proj_t project(point_t p);
		longint dx, dy, dz, w, x, y, z, one;
		longint r00, r01, r02, r10, r11, r12, r20, r21, r22, kx, ky, kz;
		proj_t o;
		dx = longint'(p.px) - longint'(p.cx);
		dy = longint'(p.py) - longint'(p.cy);
		dz = longint'(p.pz) - longint'(p.cz);
		w = p.qw; x = p.qx; y = p.qy; z = p.qz;
		one = 64'sd1 << 28;
		r00 = rnd14(one - 2 * (y * y + z * z));
		r01 = rnd14(2 * (x * y - z * w));
		r02 = rnd14(2 * (x * z + y * w));
		r10 = rnd14(2 * (x * y + z * w));
		r11 = rnd14(one - 2 * (x * x + z * z));
		r12 = rnd14(2 * (y * z - x * w));
		r20 = rnd14(2 * (x * z - y * w));
		r21 = rnd14(2 * (y * z + x * w));
		r22 = rnd14(one - 2 * (x * x + y * y));
		kx = clamp_cam(rnd14(r00 * dx + r10 * dy + r20 * dz));
		ky = clamp_cam(rnd14(r01 * dx + r11 * dy + r21 * dz));
		kz = clamp_cam(rnd14(r02 * dx + r12 * dy + r22 * dz));
		o = '{1'b0, 32'sd0, 32'sd0};
		if (kz > mind_q && in_image(fx_q, kx, cx_q, kz) && in_image(fy_q, ky, cy_q, kz)) begin
			o.vis = 1'b1;
			o.u = sat32((kx * 65536) / kz);
			o.v = sat32((ky * 65536) / kz);
		end
		return o;
	endfunction

	// register shadow and expectation store, both updated on the transfer edge
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cfg_valid && cfg_ready) begin
			n_regs <= n_regs + 1;
			case (cfg_index)
				REG_FOCAL_X: fx_q = cfg_data[23:0];
				REG_FOCAL_Y: fy_q = cfg_data[23:0];
				REG_CENTER_X: cx_q = cfg_data[23:0];
				REG_CENTER_Y: cy_q = cfg_data[23:0];
				REG_MIN_DEPTH: mind_q = cfg_data[30:0];
				default: ;
			endcase
		end
		if (start && !busy) begin
			n_taken <= n_taken + 1;
			pending_proj.push_back(typed_now ? typed_res : project('{point_x, point_y,
				point_z, cam_pos_x, cam_pos_y, cam_pos_z, quat_w, quat_x, quat_y, quat_z}));
		end
		if (done) begin
			if (pending_proj.size() == 0) begin
				$error("result with nothing expected");
				n_fail++;
			end else begin
				proj_t e;
				e = pending_proj.pop_front();
				if (visible !== e.vis) begin
					$error("visible: expected %0d, got %0d", e.vis, visible);
					n_fail++;
				end
				if (norm_u !== e.u) begin
					$error("norm_u: expected %0d, got %0d", e.u, norm_u);
					n_fail++;
				end
				if (norm_v !== e.v) begin
					$error("norm_v: expected %0d, got %0d", e.v, norm_v);
					n_fail++;
				end
			end
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic send(point_t p, bit ty, proj_t r);
		int seen;
		while ($urandom_range(99) < sender_idle) begin
			start = 0;
			@(negedge clk);
		end
		{point_x, point_y, point_z, cam_pos_x, cam_pos_y, cam_pos_z} =
			{p.px, p.py, p.pz, p.cx, p.cy, p.cz};
		{quat_w, quat_x, quat_y, quat_z} = {p.qw, p.qx, p.qy, p.qz};
		typed_now = ty;
		typed_res = r;
		seen = n_taken;
		start = 1;
		do @(negedge clk); while (n_taken == seen);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] data);
		int seen;
		start = 0;
		wait (pending_proj.size() == 0);
		repeat (45) @(posedge clk);
		@(negedge clk);
		cfg_index = idx;
		cfg_data = data;
		seen = n_regs;
		cfg_valid = 1;
		do @(negedge clk); while (n_regs == seen);
		cfg_valid = 0;
	endtask

	function automatic point_t pt(longint px, longint py, longint pz, longint cx, longint cy,
		longint cz, int qw, int qx, int qy, int qz);
		point_t p;
		p = '{px[31:0], py[31:0], pz[31:0], cx[31:0], cy[31:0], cz[31:0],
			qw[15:0], qx[15:0], qy[15:0], qz[15:0]};
		return p;
	endfunction

	function automatic row_t item(point_t p, bit ty = 0, logic vis = 0, longint u = 0,
		longint v = 0);
		row_t r;
		r.kind = ROW_POINT;
		r.pt = p;
		r.typed = ty;
		r.res = '{vis, u[31:0], v[31:0]};
		return r;
	endfunction

	function automatic row_t reg_row(logic [2:0] idx, logic [31:0] data);
		row_t r;
		r = item(pt(0, 0, 0, 0, 0, 0, 16384, 0, 0, 0));
		r.kind = ROW_REG;
		r.idx = idx;
		r.data = data;
		return r;
	endfunction

	function automatic real urand();
		return $urandom_range(1000000) / 1000000.0;
	endfunction

	// random rotation and a camera-frame point, mapped back to world coordinates
	function automatic point_t shaped_point();
		real ax, ay, az, n, a, w, x, y, z, kx, ky, kz, lim, ox, oy, oz;
		real m[9];
		point_t p;
		ax = urand() * 2 - 1; ay = urand() * 2 - 1; az = urand() * 2 - 1;
		n = $sqrt(ax * ax + ay * ay + az * az);
		if (n < 0.001) begin
			ax = 0; ay = 0; az = 1; n = 1;
		end
		a = urand() * 6.2831853;
		w = $cos(a / 2);
		x = $sin(a / 2) * ax / n; y = $sin(a / 2) * ay / n; z = $sin(a / 2) * az / n;
		m = '{1 - 2 * (y * y + z * z), 2 * (x * y - z * w), 2 * (x * z + y * w),
			2 * (x * y + z * w), 1 - 2 * (x * x + z * z), 2 * (y * z - x * w),
			2 * (x * z - y * w), 2 * (y * z + x * w), 1 - 2 * (x * x + y * y)};
		kz = urand() * 202 - 2;
		lim = fx_q > 0 ? (kz < 0 ? -kz : kz) * cx_q / fx_q * 1.2 : 5;
		if (lim > 1000) lim = 1000;
		kx = (urand() * 2 - 1) * lim;
		lim = fy_q > 0 ? (kz < 0 ? -kz : kz) * cy_q / fy_q * 1.2 : 5;
		if (lim > 1000) lim = 1000;
		ky = (urand() * 2 - 1) * lim;
		ox = urand() * 2000 - 1000; oy = urand() * 2000 - 1000; oz = urand() * 2000 - 1000;
		p = pt($rtoi((ox + m[0] * kx + m[1] * ky + m[2] * kz) * 65536),
			$rtoi((oy + m[3] * kx + m[4] * ky + m[5] * kz) * 65536),
			$rtoi((oz + m[6] * kx + m[7] * ky + m[8] * kz) * 65536),
			$rtoi(ox * 65536), $rtoi(oy * 65536), $rtoi(oz * 65536),
			$rtoi(w * 16384), $rtoi(x * 16384), $rtoi(y * 16384), $rtoi(z * 16384));
		return p;
	endfunction

	function automatic point_t noise_point();
		point_t p;
		p = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
		return p;
	endfunction

	task automatic random_phase(int count, int idle);
		point_t p;
		int sel;
		sender_idle = idle;
		repeat (count) begin
			sel = $urandom_range(99);
			if (sel < 70) p = shaped_point();
			else if (sel < 90) p = noise_point();
			else begin
				p = shaped_point();
				{p.qw, p.qx, p.qy, p.qz} = {$urandom, $urandom};
			end
			send(p, 0, '{0, 0, 0});
		end
	endtask

	initial begin
		arst_n = 0;
		start = 0;
		cfg_valid = 0;
		cfg_index = REG_FOCAL_X;
		cfg_data = 0;
		{point_x, point_y, point_z, cam_pos_x, cam_pos_y, cam_pos_z} = '0;
		{quat_w, quat_x, quat_y, quat_z} = '0;
		typed_now = 0;
		typed_res = '{0, 0, 0};
		n_taken = 0; n_regs = 0; n_fail = 0; cycles = 0; sender_idle = 0;
		fx_q = FOCAL_X_RST; fy_q = FOCAL_Y_RST; cx_q = CENTER_X_RST; cy_q = CENTER_Y_RST;
		mind_q = MIN_DEPTH_RST;

		// point at the camera, on axis, at the depth limit and just past it
		rows.push_back(item(pt(0, 0, 0, 0, 0, 0, 16384, 0, 0, 0), 1, 0, 0, 0));
		rows.push_back(item(pt(0, 0, 65536, 0, 0, 0, 16384, 0, 0, 0), 1, 1, 0, 0));
		rows.push_back(item(pt(0, 0, 3277, 0, 0, 0, 16384, 0, 0, 0), 1, 0, 0, 0));
		rows.push_back(item(pt(0, 0, 3278, 0, 0, 0, 16384, 0, 0, 0), 1, 1, 0, 0));
		rows.push_back(item(pt(5, 7, 65541, 5, 7, 5, -16384, 0, 0, 0), 1, 1, 0, 0));
		// image borders
		rows.push_back(item(pt(41943, 0, 65536, 0, 0, 0, 16384, 0, 0, 0)));
		rows.push_back(item(pt(41944, 0, 65536, 0, 0, 0, 16384, 0, 0, 0)));
		rows.push_back(item(pt(-41943, 0, 65536, 0, 0, 0, 16384, 0, 0, 0)));
		rows.push_back(item(pt(-41944, 0, 65536, 0, 0, 0, 16384, 0, 0, 0)));
		rows.push_back(item(pt(0, 31457, 65536, 0, 0, 0, 16384, 0, 0, 0)));
		rows.push_back(item(pt(0, -31458, 65536, 0, 0, 0, 16384, 0, 0, 0)));
		// quarter turns and non-unit quaternions at the field extremes
		rows.push_back(item(pt(1000, 2000, 300000, 0, 0, 0, 11585, 11585, 0, 0)));
		rows.push_back(item(pt(1000, 2000, 300000, 0, 0, 0, 11585, 0, 11585, 0)));
		rows.push_back(item(pt(1000, 2000, 300000, 0, 0, 0, 11585, 0, 0, -11585)));
		rows.push_back(item(pt(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, -64'sd2147483648,
			-64'sd2147483648, -64'sd2147483648, 32767, 32767, 32767, 32767)));
		rows.push_back(item(pt(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648,
			32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, -32768, -32768, -32768, -32768)));
		rows.push_back(item(pt(0, 0, 32'h7FFFFFFF, 0, 0, -64'sd2147483648, -32768, 0, 0, 0)));
		// zero focal length: visible once past depth, normalised value saturates
		rows.push_back(reg_row(REG_FOCAL_X, 32'hFF000000));
		rows.push_back(reg_row(REG_FOCAL_Y, 0));
		rows.push_back(item(pt(64'sd1073741824, 0, 3278, 0, 0, 0, 16384, 0, 0, 0), 1, 1,
			32'sh7FFFFFFF, 0));
		rows.push_back(item(pt(-64'sd1073741824, 0, 3278, 0, 0, 0, 16384, 0, 0, 0), 1, 1,
			-64'sd2147483648, 0));
		// zero centre: empty image; unknown indexes change nothing
		rows.push_back(reg_row(REG_CENTER_X, 0));
		rows.push_back(reg_row(REG_UNUSED_HI, 32'hFFFFFFFF));
		rows.push_back(reg_row(REG_UNUSED_LO, 32'h12345678));
		rows.push_back(item(pt(0, 0, 65536, 0, 0, 0, 16384, 0, 0, 0), 1, 0, 0, 0));
		// largest registers; the depth limit at its top value, passed by the first point and not the second
		rows.push_back(reg_row(REG_FOCAL_X, 32'hFFFFFFFF));
		rows.push_back(reg_row(REG_CENTER_X, 32'hFFFFFFFF));
		rows.push_back(reg_row(REG_CENTER_Y, 32'hFFFFFFFF));
		rows.push_back(reg_row(REG_MIN_DEPTH, 32'hFFFFFFFF));
		rows.push_back(item(pt(0, 0, 32'h7FFFFFFF, 0, 0, -64'sd2147483648, 16384, 0, 0, 0)));
		rows.push_back(item(pt(0, 0, 32'h7FFFFFFF, 0, 0, 0, 16384, 0, 0, 0), 1, 0, 0, 0));

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		foreach (rows[i]) begin
			if (rows[i].kind == ROW_REG) write_reg(rows[i].idx, rows[i].data);
			else send(rows[i].pt, rows[i].typed, rows[i].res);
		end

		write_reg(REG_FOCAL_X, FOCAL_X_RST);
		write_reg(REG_FOCAL_Y, FOCAL_Y_RST);
		write_reg(REG_CENTER_X, CENTER_X_RST);
		write_reg(REG_CENTER_Y, CENTER_Y_RST);
		write_reg(REG_MIN_DEPTH, MIN_DEPTH_RST);
		random_phase(700, 6);

		write_reg(REG_FOCAL_X, $urandom_range(400000, 1000));
		write_reg(REG_FOCAL_Y, $urandom_range(400000, 1000));
		write_reg(REG_CENTER_X, $urandom_range(200000, 1));
		write_reg(REG_CENTER_Y, $urandom_range(200000, 1));
		write_reg(REG_MIN_DEPTH, $urandom_range(200000, 0));
		random_phase(650, 67);

		write_reg(REG_FOCAL_X, 24'hFFFFFF);
		write_reg(REG_FOCAL_Y, 1);
		write_reg(REG_CENTER_X, 24'hFFFFFF);
		write_reg(REG_CENTER_Y, 1);
		write_reg(REG_MIN_DEPTH, 0);
		random_phase(650, 0);

		start = 0;
		wait (pending_proj.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_fail == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end

endmodule

// File: sim.f
rtl/core/ppp_pkg.sv
rtl/core/ppp_front.sv
rtl/core/ppp_fifo.sv
rtl/core/ppp_div.sv
rtl/core/ppp_back.sv
rtl/core/pinhole_point_projection.sv
rtl/core/ppp_check.sv
bench/tb_pinhole_point_projection.sv
